// File: rtl/core/sfd_pkg.sv
// ---------------------------------------------------------------------------
// sfd_pkg
// Shared types and codes for the serial frame deframer.
// ---------------------------------------------------------------------------
package sfd_pkg;

  // input word kinds
  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_READ    = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;

  // result status codes
  localparam logic [2:0] ST_ABSORBED = 3'd0;
  localparam logic [2:0] ST_READY    = 3'd1;
  localparam logic [2:0] ST_DROPPED  = 3'd2;
  localparam logic [2:0] ST_REJECTED = 3'd3;
  localparam logic [2:0] ST_READ     = 3'd4;
  localparam logic [2:0] ST_RELEASED = 3'd5;

  // register indexes (byte address bits [3:2])
  localparam logic [1:0] REG_START_MARKER = 2'd0;
  localparam logic [1:0] REG_END_MARKER   = 2'd1;
  localparam logic [1:0] REG_MAX_LENGTH   = 2'd2;

  localparam logic [7:0] RST_START_MARKER = 8'd2;
  localparam logic [7:0] RST_END_MARKER   = 8'd3;
  localparam logic [7:0] RST_MAX_LENGTH   = 8'd255;

  // start, length, command and end bytes
  localparam logic [7:0] HDR_TRL_LEN = 8'd4;

  typedef struct packed {
    logic [7:0] start_marker;
    logic [7:0] end_marker;
    logic [7:0] max_length;
  } cfg_t;

  typedef struct packed {
    logic       en;
    logic [7:0] slot;
    logic [7:0] data;
  } wr_req_t;

  typedef struct packed {
    logic       en;
    logic [7:0] slot;
  } rd_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] command;
    logic [7:0] body_count;
    logic       hit;
  } res_t;

endpackage

// File: rtl/core/serial_frame_deframer_core.sv
// ---------------------------------------------------------------------------
// serial_frame_deframer_core
// Start/length/end byte frame receiver with indexed data readout.
// ---------------------------------------------------------------------------
// Path: accepted word -> read stage (store read) -> output register.
// Throughput: one word per cycle on both channels unless the output stalls; the
//   store's own write and registered read ports keep parse and read from waiting.
// Reset: parser hunts for a start byte, no frame pending, registers at
//   their defaults; the body store has no reset and needs no clearing pass.
// ---------------------------------------------------------------------------
module serial_frame_deframer_core #(
  parameter int STORE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input words
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [7:0]  read_index_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [7:0]  command_o,
  output logic [7:0]  body_count_o,
  output logic [7:0]  read_data_o
);
  import sfd_pkg::*;

  cfg_t       cfg;
  wr_req_t    wr_req;
  rd_req_t    rd_req;
  res_t       res;
  logic [7:0] rdata;
  logic       accept;
  logic       adv;

  logic       s1_valid_q;
  res_t       s1_res_q;
  logic       out_valid_q;
  logic [2:0] status_q;
  logic [7:0] command_q;
  logic [7:0] body_count_q;
  logic [7:0] read_data_q;

  sfd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sfd_parser #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .kind_i       (kind_i),
    .rx_byte_i    (rx_byte_i),
    .read_index_i (read_index_i),
    .cfg_i        (cfg),
    .wr_o         (wr_req),
    .rd_o         (rd_req),
    .res_o        (res)
  );

  sfd_store #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .wr_i    (wr_req),
    .rd_i    (rd_req),
    .rdata_o (rdata)
  );

  // stage 1 waits on the store read, stage 2 is the output register
  assign adv        = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !adv;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_res_q <= res;
    end
    if (adv) begin
      status_q     <= s1_res_q.status;
      command_q    <= s1_res_q.command;
      body_count_q <= s1_res_q.body_count;
      read_data_q  <= s1_res_q.hit ? rdata : 8'd0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign command_o    = command_q;
  assign body_count_o = body_count_q;
  assign read_data_o  = read_data_q;

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !adv) |=>
      (s1_valid_q && $stable(s1_res_q) && (!s1_res_q.hit || $stable(rdata))))
    else $error("read stage lost its word while blocked");

  a_no_accept_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && out_stall_i) |-> !accept)
    else $error("word taken with both stages full");

endmodule

// File: rtl/core/sfd_cfg.sv
// ---------------------------------------------------------------------------
// sfd_cfg
// APB register file for the frame markers and the length limit.
// ---------------------------------------------------------------------------
module sfd_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output sfd_pkg::cfg_t cfg_o
);
  import sfd_pkg::*;

  cfg_t cfg_q;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_marker <= RST_START_MARKER;
      cfg_q.end_marker   <= RST_END_MARKER;
      cfg_q.max_length   <= RST_MAX_LENGTH;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_START_MARKER: cfg_q.start_marker <= pwdata[7:0];
        REG_END_MARKER:   cfg_q.end_marker   <= pwdata[7:0];
        REG_MAX_LENGTH:   cfg_q.max_length   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_START_MARKER: prdata = {24'd0, cfg_q.start_marker};
      REG_END_MARKER:   prdata = {24'd0, cfg_q.end_marker};
      REG_MAX_LENGTH:   prdata = {24'd0, cfg_q.max_length};
      default:          prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/sfd_store.sv
// ---------------------------------------------------------------------------
// sfd_store
// Frame body memory: one write port, one registered read port.
// ---------------------------------------------------------------------------
module sfd_store #(
  parameter int STORE_DEPTH = 256
) (
  input  logic             clk_i,
  input  sfd_pkg::wr_req_t wr_i,
  input  sfd_pkg::rd_req_t rd_i,
  output logic [7:0]       rdata_o
);
  import sfd_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);

  logic [7:0] mem_q [STORE_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.slot[AW-1:0]] <= wr_i.data;
    end
  end

  // holds while the read stage is stalled; only a new read moves it
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rdata_q <= mem_q[rd_i.slot[AW-1:0]];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/sfd_parser.sv
// ---------------------------------------------------------------------------
// sfd_parser
// Frame parse state machine, pending flag and store address generation.
// ---------------------------------------------------------------------------
module sfd_parser #(
  parameter int STORE_DEPTH = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [1:0]       kind_i,
  input  logic [7:0]       rx_byte_i,
  input  logic [7:0]       read_index_i,
  input  sfd_pkg::cfg_t    cfg_i,
  output sfd_pkg::wr_req_t wr_o,
  output sfd_pkg::rd_req_t rd_o,
  output sfd_pkg::res_t    res_o
);
  import sfd_pkg::*;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_LEN,
    PH_BODY
  } phase_e;

  localparam logic [8:0] DepthW = 9'(STORE_DEPTH);

  phase_e     phase_q, phase_d;
  logic [7:0] bytes_taken_q, bytes_taken_d;
  logic [7:0] frame_length_q, frame_length_d;
  logic [7:0] cmd_q, cmd_d;
  logic [7:0] held_command_q, held_command_d;
  logic [7:0] held_count_q, held_count_d;
  logic       frame_pending_q, frame_pending_d;
  logic [2:0] status;
  logic [7:0] slot;
  logic [8:0] rd_slot;
  logic       hit;

  assign slot    = bytes_taken_q - 8'd2;
  assign rd_slot = {1'b0, read_index_i} + 9'd1;
  assign hit     = (read_index_i < held_count_q) && (rd_slot < DepthW);

  always_comb begin
    phase_d         = phase_q;
    bytes_taken_d   = bytes_taken_q;
    frame_length_d  = frame_length_q;
    cmd_d           = cmd_q;
    held_command_d  = held_command_q;
    held_count_d    = held_count_q;
    frame_pending_d = frame_pending_q;
    status          = ST_ABSORBED;
    wr_o            = '0;
    wr_o.slot       = slot;
    wr_o.data       = rx_byte_i;
    rd_o.en         = 1'b0;
    rd_o.slot       = rd_slot[7:0];

    unique case (kind_i)
      KIND_BYTE: begin
        if (frame_pending_q) begin
          status = ST_DROPPED;
        end else begin
          unique case (phase_q)
            PH_HUNT: begin
              if (rx_byte_i != cfg_i.start_marker) begin
                status = ST_REJECTED;
              end else begin
                phase_d       = PH_LEN;
                bytes_taken_d = 8'd1;
              end
            end
            PH_LEN: begin
              if (rx_byte_i > cfg_i.max_length || rx_byte_i < HDR_TRL_LEN) begin
                phase_d        = PH_HUNT;
                bytes_taken_d  = 8'd0;
                frame_length_d = 8'd0;
                status         = ST_REJECTED;
              end else begin
                frame_length_d = rx_byte_i;
                bytes_taken_d  = 8'd2;
                phase_d        = PH_BODY;
              end
            end
            PH_BODY: begin
              // this byte is the end marker position
              if ({1'b0, bytes_taken_q} + 9'd1 >= {1'b0, frame_length_q}) begin
                if (rx_byte_i != cfg_i.end_marker) begin
                  status = ST_REJECTED;
                end else begin
                  held_command_d  = cmd_q;
                  held_count_d    = frame_length_q - HDR_TRL_LEN;
                  frame_pending_d = 1'b1;
                  status          = ST_READY;
                end
                phase_d        = PH_HUNT;
                bytes_taken_d  = 8'd0;
                frame_length_d = 8'd0;
              end else begin
                wr_o.en = ({1'b0, slot} < DepthW);
                // slot zero holds the command byte
                if (slot == 8'd0) begin
                  cmd_d = rx_byte_i;
                end
                bytes_taken_d = bytes_taken_q + 8'd1;
              end
            end
            default: begin
              phase_d        = PH_HUNT;
              bytes_taken_d  = 8'd0;
              frame_length_d = 8'd0;
            end
          endcase
        end
      end
      KIND_READ: begin
        status  = ST_READ;
        rd_o.en = hit;
      end
      KIND_RELEASE: begin
        frame_pending_d = 1'b0;
        status          = ST_RELEASED;
      end
      default: ;
    endcase

    wr_o.en = wr_o.en & accept_i;
    rd_o.en = rd_o.en & accept_i;

    res_o.status     = status;
    res_o.command    = held_command_d;
    res_o.body_count = held_count_d;
    res_o.hit        = (kind_i == KIND_READ) && hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_HUNT;
      bytes_taken_q   <= 8'd0;
      frame_length_q  <= 8'd0;
      cmd_q           <= 8'd0;
      held_command_q  <= 8'd0;
      held_count_q    <= 8'd0;
      frame_pending_q <= 1'b0;
    end else if (accept_i) begin
      phase_q         <= phase_d;
      bytes_taken_q   <= bytes_taken_d;
      frame_length_q  <= frame_length_d;
      cmd_q           <= cmd_d;
      held_command_q  <= held_command_d;
      held_count_q    <= held_count_d;
      frame_pending_q <= frame_pending_d;
    end
  end

  a_hunt_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_HUNT) |-> (bytes_taken_q == 8'd0 && frame_length_q == 8'd0))
    else $error("hunt with stale frame counters");

  a_body_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BODY) |->
      (bytes_taken_q < frame_length_q && frame_length_q >= HDR_TRL_LEN))
    else $error("body position past frame end");

  a_pending_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && frame_pending_q && kind_i == KIND_BYTE) |=>
      ($stable(phase_q) && $stable(bytes_taken_q) && frame_pending_q))
    else $error("parser moved while frame pending");

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the serial frame deframer core.
// Sends received bytes, reads and releases through the input channel and
// predicts every result word from its own copy of the parser state. It
// checks the results in order, field by field, with random gaps on the
// input side and random stalls on the output side. The markers and the
// length limit are changed through the register port between phases.
// ----------------------------------------------------------------------------
import sfd_pkg::*;

class frame_scoreboard #(int DEPTH = 256);
  typedef enum logic [1:0] {HUNT, GET_LEN, BODY} parse_e;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] command;
    logic [7:0] body_count;
    logic [7:0] read_data;
  } result_t;

  logic [7:0]  start_marker;
  logic [7:0]  end_marker;
  logic [7:0]  max_length;
  logic [7:0]  body_mem [DEPTH];
  int unsigned taken;
  int unsigned flen;
  parse_e      parse;
  logic [7:0]  cmd_held;
  logic [7:0]  count_held;
  bit          pending;
  result_t     expected_q [$];
  int          errors;

  function new();
    start_marker = RST_START_MARKER;
    end_marker   = RST_END_MARKER;
    max_length   = RST_MAX_LENGTH;
    cmd_held     = '0;
    count_held   = '0;
    pending      = 1'b0;
    errors       = 0;
    rehunt();
  endfunction

  function void rehunt();
    parse = HUNT;
    taken = 0;
    flen  = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [7:0] val);
    case (idx)
      REG_START_MARKER: start_marker = val;
      REG_END_MARKER:   end_marker   = val;
      REG_MAX_LENGTH:   max_length   = val;
      default: ;
    endcase
  endfunction

  function logic [2:0] absorb_byte(logic [7:0] b);
    if (pending) return ST_DROPPED;
    if (parse == HUNT) begin
      if (b != start_marker) return ST_REJECTED;
      parse = GET_LEN;
      taken = 1;
      return ST_ABSORBED;
    end
    if (parse == GET_LEN) begin
      if (b > max_length || b < HDR_TRL_LEN) begin
        rehunt();
        return ST_REJECTED;
      end
      flen  = b;
      taken = 2;
      parse = BODY;
      return ST_ABSORBED;
    end
    // taken is the position of this byte within the frame
    if (taken + 1 >= flen) begin
      if (b != end_marker) begin
        rehunt();
        return ST_REJECTED;
      end
      cmd_held   = body_mem[0];
      count_held = 8'(flen - HDR_TRL_LEN);
      pending    = 1'b1;
      rehunt();
      return ST_READY;
    end
    if (taken - 2 < DEPTH) body_mem[taken - 2] = b;
    taken = (taken + 1) & 32'hFF;
    return ST_ABSORBED;
  endfunction

  function logic [2:0] note_input(logic [1:0] kind, logic [7:0] rx, logic [7:0] idx);
    result_t r;
    int      slot;
    r.status    = ST_ABSORBED;
    r.read_data = '0;
    slot        = int'(idx) + 1;
    case (kind)
      KIND_BYTE: r.status = absorb_byte(rx);
      KIND_READ: begin
        r.status = ST_READ;
        if (idx < count_held && slot < DEPTH) r.read_data = body_mem[slot];
      end
      KIND_RELEASE: begin
        pending  = 1'b0;
        r.status = ST_RELEASED;
      end
      default: ;
    endcase
    r.command    = cmd_held;
    r.body_count = count_held;
    expected_q.push_back(r);
    return r.status;
  endfunction

  function void match(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      errors++;
    end
  endfunction

  function void check_result(logic [2:0] status, logic [7:0] command,
                             logic [7:0] body_count, logic [7:0] read_data);
    result_t want;
    if (expected_q.size() == 0) begin
      $error("result word with nothing expected (status %0d)", status);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    match("status", 8'(want.status), 8'(status));
    match("command", want.command, command);
    match("body_count", want.body_count, body_count);
    match("read_data", want.read_data, read_data);
  endfunction
endclass

module tb;
  localparam int         STORE_DEPTH = 256;
  localparam int         CYCLE_LIMIT = 1_000_000;
  localparam int         PHASE_WORDS = 110;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  kind_i;
  logic [7:0]  rx_byte_i;
  logic [7:0]  read_index_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  status_o;
  logic [7:0]  command_o;
  logic [7:0]  body_count_o;
  logic [7:0]  read_data_o;

  frame_scoreboard #(STORE_DEPTH) sb;
  int cycles = 0;
  int calm_left;
  int useful_words;

  serial_frame_deframer_core #(.STORE_DEPTH(STORE_DEPTH)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .rx_byte_i    (rx_byte_i),
    .read_index_i (read_index_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .command_o    (command_o),
    .body_count_o (body_count_o),
    .read_data_o  (read_data_o)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0)
      sb.check_result(status_o, command_o, body_count_o, read_data_o);
  end

  // output stalls, with stretches of none at all
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i = 1'b0;
      if ($urandom_range(0, 19) == 0) begin
        repeat ($urandom_range(30, 150)) @(negedge clk_i);
      end else begin
        repeat (gap_len()) begin
          @(negedge clk_i);
          out_stall_i = 1'b1;
        end
      end
    end
  end

  task automatic send_word(logic [1:0] kind, logic [7:0] rx, logic [7:0] idx);
    int         gap;
    logic [2:0] st;
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else if ($urandom_range(0, 39) == 0) begin
      calm_left = $urandom_range(20, 100);
      gap = 0;
    end else begin
      gap = gap_len();
    end
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    in_valid_i   = 1'b1;
    kind_i       = kind;
    rx_byte_i    = rx;
    read_index_i = idx;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    st = sb.note_input(kind, rx, idx);
    if (kind != KIND_UNUSED && st != ST_DROPPED) useful_words++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_word(KIND_BYTE, b, 8'($urandom));
  endtask

  task automatic read_at(logic [7:0] idx);
    send_word(KIND_READ, 8'($urandom), idx);
  endtask

  task automatic release_frame();
    send_word(KIND_RELEASE, 8'($urandom), 8'($urandom));
  endtask

  // sender holds off until every result word is back
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = {24'h0, val};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    sb.set_reg(idx, val);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic send_frame(logic [7:0] cmd, int n, bit good_end);
    send_byte(sb.start_marker);
    send_byte(8'(n + 4));
    send_byte(cmd);
    for (int i = 0; i < n; i++) send_byte(8'($urandom));
    if (good_end) send_byte(sb.end_marker);
    else send_byte(sb.end_marker ^ 8'($urandom_range(1, 255)));
  endtask

  function automatic int pick_count();
    int maxn = int'(sb.max_length) - 4;
    int r    = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, (maxn < 8) ? maxn : 8);
    if (r < 95) return $urandom_range(0, (maxn < 40) ? maxn : 40);
    return $urandom_range(0, maxn);
  endfunction

  task automatic run_good_frame();
    logic [7:0] b;
    if (sb.pending) release_frame();
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0) begin
      b = 8'($urandom);
      if (b == sb.start_marker) b = b ^ 8'h01;
      send_byte(b);
    end
    send_frame(8'($urandom), pick_count(), 1'b1);
    repeat ($urandom_range(1, 5)) begin
      if (sb.count_held > 0 && $urandom_range(0, 3) != 0)
        read_at(8'($urandom_range(0, int'(sb.count_held) - 1)));
      else
        read_at(8'($urandom));
    end
    if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
    if ($urandom_range(0, 9) != 0) begin
      release_frame();
      // a read after release still sees the released frame's body
      if ($urandom_range(0, 3) == 0 && sb.count_held > 0)
        read_at(8'($urandom_range(0, int'(sb.count_held) - 1)));
    end
  endtask

  task automatic run_bad_frame();
    if (sb.pending) release_frame();
    case ($urandom_range(0, 2))
      0: begin
        send_byte(sb.start_marker);
        send_byte(8'($urandom_range(0, 3)));
      end
      1: begin
        send_byte(sb.start_marker);
        if (sb.max_length == 8'hFF) send_byte(8'($urandom_range(0, 3)));
        else send_byte(8'($urandom_range(int'(sb.max_length) + 1, 255)));
      end
      default: send_frame(8'($urandom), pick_count(), 1'b0);
    endcase
  endtask

  task automatic run_noise();
    repeat ($urandom_range(1, 8))
      send_word(2'($urandom), 8'($urandom), 8'($urandom));
  endtask

  initial begin
    logic [7:0] st;
    logic [7:0] en;
    logic [7:0] mx;
    int         target;
    int         r;
    sb           = new();
    calm_left    = 0;
    useful_words = 0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid_i   = 1'b0;
    kind_i       = KIND_BYTE;
    rx_byte_i    = '0;
    read_index_i = '0;
    rst_ni       = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed checks at the reset register values
    send_word(KIND_UNUSED, 8'hFF, 8'hFF);
    read_at(8'h00);
    release_frame();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(RST_START_MARKER);
    send_byte(8'd3);
    send_byte(RST_START_MARKER);
    send_byte(8'd4);
    send_byte(8'hA5);
    send_byte(8'h04);
    send_frame(8'hFF, 0, 1'b1);
    send_byte(RST_START_MARKER);
    read_at(8'h00);
    release_frame();
    // start marker inside the body is plain data
    send_byte(RST_START_MARKER);
    send_byte(8'd7);
    send_byte(8'h00);
    send_byte(RST_START_MARKER);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(RST_END_MARKER);
    read_at(8'd0);
    read_at(8'd2);
    read_at(8'd3);
    read_at(8'hFF);
    release_frame();

    for (int p = 1; p <= 7; p++) begin
      wait_idle();
      case (p)
        1: begin st = 8'h00; en = 8'hFF; mx = 8'd4;   end
        2: begin st = 8'hFF; en = 8'h00; mx = 8'd255; end
        3: begin st = 8'h7E; en = 8'h7E; mx = 8'd20;  end
        default: begin
          st = 8'($urandom);
          en = 8'($urandom);
          mx = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(4, 255))
                                           : 8'($urandom_range(4, 40));
        end
      endcase
      write_reg(REG_START_MARKER, st);
      write_reg(REG_END_MARKER, en);
      write_reg(REG_MAX_LENGTH, mx);
      if (p == 1) begin
        send_byte(st);
        send_byte(8'd5);
      end
      if (p == 2) begin
        send_frame(8'($urandom), 251, 1'b1);
        read_at(8'd250);
        read_at(8'd0);
        release_frame();
      end
      target = useful_words + PHASE_WORDS;
      while (useful_words < target) begin
        r = $urandom_range(0, 99);
        if (r < 60) run_good_frame();
        else if (r < 80) run_bad_frame();
        else if (r < 97) run_noise();
        else wait_idle();
      end
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// File: filelist.f
rtl/core/sfd_pkg.sv
rtl/core/sfd_cfg.sv
rtl/core/sfd_store.sv
rtl/core/sfd_parser.sv
rtl/core/serial_frame_deframer_core.sv
sim/tb.sv
